FILE: rtl/core/lkvc_pkg.sv
// ============================================================================
// lkvc_pkg
// Shared sizes, codes and bundle types of the LRU key/value cache.
// ============================================================================
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES  = 8;
    localparam int KEY_BITS = 64;

    // Widths of the item and result fields and of the capacity register.
    localparam int KEY_W   = 64;
    localparam int ADDR_W  = 32;
    localparam int CAP_W   = 4;

    // Widths derived from the entry count.
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic
    {
        KIND_LOOKUP  = 1'b0,
        KIND_REFRESH = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic               backing_found;
        logic [ADDR_W-1:0]  backing_address;
    } item_t;

    typedef struct packed
    {
        logic               removed;
        logic               evicted;
        logic [ADDR_W-1:0]  address;
        logic               address_valid;
        logic               hit;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic match;
        logic update;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/lru_key_value_cache.sv
// ============================================================================
// lru_key_value_cache
// Fully associative key/address cache with least-recently-used replacement.
// ============================================================================
//
//  port group      dir   word contents
//  s_axis_*        in    tuser: kind; tdata: key, backing_found, backing_address
//  m_axis_*        out   tdata: hit, address_valid, address, evicted, removed
//  APB             in    register 0: capacity
//
//  An item runs through the eight-way tag compare, then through the rank
//  and entry update. The next word is taken in the update cycle.
//  The result register lets one result wait while the next item is compared.
//  A stalled result holds the update, and with it the input side.
//  Reset clears all valid bits at once; no clearing pass is needed.
//
`default_nettype none

module lru_key_value_cache
(
    input  wire          clk,
    input  wire          rst_n,

    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [103:0]  s_axis_tdata,   // key[63:0], backing_found[64],
                                         // backing_address[96:65], zero pad
    input  wire          s_axis_tuser,   // kind

    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // hit[0], address_valid[1], address[33:2],
                                         // evicted[34], removed[35], zero pad

    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;
    lkvc_pkg::cmd_t             cmd;
    lkvc_pkg::item_t            item;
    lkvc_pkg::result_t          result;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_write && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_CAPACITY)
        begin
            prdata = 32'(capacity_reg);
        end
    end

    always_comb
    begin
        item.kind            = lkvc_pkg::kind_t'(s_axis_tuser);
        item.key             = s_axis_tdata[63:0];
        item.backing_found   = s_axis_tdata[64];
        item.backing_address = s_axis_tdata[96:65];
    end

    assign m_axis_tdata = {4'b0, result.removed, result.evicted, result.address,
                           result.address_valid, result.hit};

    lkvc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    lkvc_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item_in  (item),
        .capacity (capacity_reg),
        .result   (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lkvc_ctrl.sv
// ============================================================================
// lkvc_ctrl
// Sequencer: takes a word, runs the tag compare, then the table update,
// and keeps the result valid flag.
// ============================================================================
`default_nettype none

module lkvc_ctrl
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire               out_ready,
    output lkvc_pkg::cmd_t    cmd
);

    lkvc_pkg::state_t state_reg;
    lkvc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             upd_go;
    logic             accept;

    // The update may only retire once the output register is free.
    assign upd_go = (state_reg == lkvc_pkg::ST_UPDATE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lkvc_pkg::ST_MATCH;
                end
            end
            lkvc_pkg::ST_MATCH:
            begin
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = accept ? lkvc_pkg::ST_MATCH : lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.match  = 1'b0;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:   in_ready  = 1'b1;
            lkvc_pkg::ST_MATCH:  cmd.match = 1'b1;
            lkvc_pkg::ST_UPDATE: in_ready  = upd_go;
            default:             in_ready  = 1'b0;
        endcase
        cmd.load   = in_valid && in_ready;
        cmd.update = upd_go;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A held result is never overwritten by the next update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.update)
        else $error("lkvc_ctrl: update while result is stalled");

    // Every compare is followed by the update state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.match |=> (state_reg == lkvc_pkg::ST_UPDATE))
        else $error("lkvc_ctrl: compare not followed by update");

    // No word is taken while a compare is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load || $past(cmd.update))
        else $error("lkvc_ctrl: word accepted mid-item");

endmodule

`default_nettype wire

FILE: rtl/core/lkvc_dpath.sv
// ============================================================================
// lkvc_dpath
// Entry table, parallel tag compare, recency rank update and result register.
// ============================================================================
`default_nettype none

module lkvc_dpath
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  lkvc_pkg::cmd_t                 cmd,
    input  lkvc_pkg::item_t                item_in,
    input  wire [lkvc_pkg::CAP_W-1:0]      capacity,
    output lkvc_pkg::result_t              result
);

    localparam int N  = lkvc_pkg::ENTRIES;
    localparam int KB = lkvc_pkg::KEY_BITS;
    localparam int RW = lkvc_pkg::RANK_W;
    localparam int CW = lkvc_pkg::CNT_W;
    localparam int AW = lkvc_pkg::ADDR_W;

    lkvc_pkg::item_t    item_reg;

    logic [N-1:0]       valid_reg;
    logic [N-1:0]       valid_next;
    logic [KB-1:0]      key_reg   [N];
    logic [AW-1:0]      addr_reg  [N];
    logic [RW-1:0]      rank_reg  [N];
    logic [RW-1:0]      rank_next [N];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic [N-1:0]       match_reg;
    logic [N-1:0]       match_next;
    logic [RW-1:0]      hit_rank_reg;
    logic [RW-1:0]      hit_rank_next;
    logic [AW-1:0]      hit_addr_reg;
    logic [AW-1:0]      hit_addr_next;

    lkvc_pkg::result_t  res_reg;
    lkvc_pkg::result_t  res_next;

    logic [31:0]        cap_wide;
    logic [CW-1:0]      eff_cap;
    logic [CW-1:0]      cap_m1;
    logic               full;
    logic               is_hit;
    logic               do_fill;
    logic               do_remove;
    logic [N-1:0]       evict_mask;
    logic [N-1:0]       kept;
    logic [N-1:0]       free_onehot;
    logic               free_found;

    // Parallel tag compare against every valid entry.
    always_comb
    begin
        hit_rank_next = '0;
        hit_addr_next = '0;
        for (int i = 0; i < N; i++)
        begin
            match_next[i] = valid_reg[i] && (key_reg[i] == item_reg.key[KB-1:0]);
            if (match_next[i])
            begin
                hit_rank_next = hit_rank_next | rank_reg[i];
                hit_addr_next = hit_addr_next | addr_reg[i];
            end
        end
    end

    // Capacity of zero acts as one, anything above the table size as the size.
    always_comb
    begin
        cap_wide = 32'(capacity);
        if (cap_wide == 32'd0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_wide > 32'(N))
        begin
            eff_cap = CW'(N);
        end
        else
        begin
            eff_cap = CW'(cap_wide);
        end
        cap_m1 = eff_cap - CW'(1);
    end

    assign is_hit    = |match_reg;
    assign do_fill   = (item_reg.kind == lkvc_pkg::KIND_LOOKUP) && !is_hit
                       && item_reg.backing_found;
    assign do_remove = (item_reg.kind == lkvc_pkg::KIND_REFRESH) && is_hit
                       && !item_reg.backing_found;
    assign full      = count_reg >= eff_cap;

    // When full, eviction drops every entry at or beyond the last allowed rank.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            evict_mask[i] = full && valid_reg[i] && (CW'(rank_reg[i]) >= cap_m1);
        end
        kept = valid_reg & ~evict_mask;
    end

    // Lowest free slot after eviction.
    always_comb
    begin
        free_onehot = '0;
        free_found  = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (!kept[i] && !free_found)
            begin
                free_onehot[i] = 1'b1;
                free_found     = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (item_reg.kind == lkvc_pkg::KIND_LOOKUP)
        begin
            if (is_hit)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (match_reg[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end
            else if (do_fill)
            begin
                valid_next = kept | free_onehot;
                for (int i = 0; i < N; i++)
                begin
                    if (free_onehot[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end
        end
        else if (do_remove)
        begin
            valid_next = valid_reg & ~match_reg;
            for (int i = 0; i < N; i++)
            begin
                if (valid_next[i] && (rank_reg[i] > hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] - RW'(1);
                end
            end
        end
        count_next = CW'($countones(valid_next));
    end

    always_comb
    begin
        res_next.hit     = is_hit;
        res_next.evicted = do_fill && (|evict_mask);
        res_next.removed = do_remove;
        if (item_reg.kind == lkvc_pkg::KIND_LOOKUP)
        begin
            res_next.address_valid = is_hit || item_reg.backing_found;
            res_next.address       = is_hit ? hit_addr_reg
                                   : (item_reg.backing_found ? item_reg.backing_address
                                                             : '0);
        end
        else
        begin
            res_next.address_valid = item_reg.backing_found;
            res_next.address       = item_reg.backing_found ? item_reg.backing_address
                                                            : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
        if (cmd.match)
        begin
            match_reg    <= match_next;
            hit_rank_reg <= hit_rank_next;
            hit_addr_reg <= hit_addr_next;
        end
        if (cmd.update)
        begin
            res_reg <= res_next;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= rank_next[i];
                if (do_fill && free_onehot[i])
                begin
                    key_reg[i]  <= item_reg.key[KB-1:0];
                    addr_reg[i] <= item_reg.backing_address;
                end
                else if ((item_reg.kind == lkvc_pkg::KIND_REFRESH) && match_reg[i]
                         && item_reg.backing_found)
                begin
                    addr_reg[i] <= item_reg.backing_address;
                end
            end
        end
    end

    assign result = res_reg;

    // Keys are unique, so at most one entry matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $onehot0(match_reg))
        else $error("lkvc_dpath: multiple tag matches");

    // The fill level always tracks the valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_reg))
        else $error("lkvc_dpath: entry count out of step");

    // A fill always lands in a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && do_fill) |-> free_found)
        else $error("lkvc_dpath: fill found no free slot");

endmodule

`default_nettype wire
